>>> rtl/assert_macros.svh
// Assertion macros shared by the timer block.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lat_pkg.sv
// Shared types and constants for the local interrupt controller timer.
// Depends on nothing.
`default_nettype none

package lat_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [5:0] IDX_ID   = 6'h02;
    localparam logic [5:0] IDX_TPR  = 6'h08;
    localparam logic [5:0] IDX_SPUR = 6'h0F;
    localparam logic [5:0] IDX_LVT  = 6'h32;
    localparam logic [5:0] IDX_INIT = 6'h38;
    localparam logic [5:0] IDX_CURR = 6'h39;
    localparam logic [5:0] IDX_DIV  = 6'h3E;

    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [2:0] SEL_DIV_ONE   = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  reg_index;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_fire;
        logic [7:0]  irq_vector;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/local_apic_timer_registers.sv
// Top level of the local interrupt controller timer: handshakes, word and result registers.
// Depends on lat_pkg, lat_core and assert_macros.svh.
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_stall    cmd, reg_index, write_data
//  output    out        out_valid / out_stall  read_data, irq_fire, irq_vector
//  config    in         APB psel/penable       paddr, pwdata, prdata
//
// An accepted word sits in the word register while the register and timer logic computes
// its result, which is loaded into the result register when the result side advances.
// One word is accepted every cycle while the result side does not stall.
// Reset empties both stages and resets unit id and timer state, not word or result data.
// A stalled result holds the word register, which then stalls the input.
`default_nettype none

module local_apic_timer_registers (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [5:0]  reg_index,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [31:0] read_data,
    output logic             irq_fire,
    output logic      [7:0]  irq_vector
);

    `include "assert_macros.svh"

    logic [7:0]        unit_id_reg;
    logic              in_valid_reg;
    lat_pkg::item_t    item_reg;
    logic              out_valid_reg;
    lat_pkg::result_t  result_reg;
    lat_pkg::result_t  result_next;
    logic              advance;
    logic              accept;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, unit_id_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_id_reg <= '0;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            unit_id_reg <= pwdata[7:0];
        end
    end

    lat_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (in_valid_reg && advance),
        .unit_id (unit_id_reg),
        .item    (item_reg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{cmd: cmd, reg_index: reg_index, write_data: write_data};
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = result_reg.read_data;
    assign irq_fire   = result_reg.irq_fire;
    assign irq_vector = result_reg.irq_vector;

    `ASSERT_CLK(a_fire_not_read, out_valid_reg && irq_fire |-> read_data == 32'd0,
        "interrupt on a read word")
    `ASSERT_ALWAYS(a_stall_needs_word, in_stall |-> in_valid_reg,
        "input stalled with an empty word register")
    `ASSERT_CLK(a_word_held, in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg),
        "held word lost")

endmodule

`default_nettype wire

>>> rtl/lat_core.sv
// Register file and timer state: executes one bus word per enabled cycle.
// Depends on lat_pkg.
`default_nettype none

module lat_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire logic [7:0]      unit_id,
    input  wire lat_pkg::item_t  item,
    output lat_pkg::result_t     result
);

    logic [8:0]                      spurious_reg, spurious_next;
    logic [7:0]                      tpr_reg, tpr_next;
    logic [7:0]                      vector_reg, vector_next;
    logic                            masked_reg, masked_next;
    logic [1:0]                      mode_reg, mode_next;
    logic [3:0]                      div_reg, div_next;
    logic [lat_pkg::COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [lat_pkg::COUNT_WIDTH-1:0] remain_reg, remain_next;
    logic [6:0]                      prescale_reg, prescale_next;

    logic [2:0]                      div_sel;
    logic [7:0]                      divisor;
    logic [7:0]                      prescale_inc;
    logic [lat_pkg::COUNT_WIDTH-1:0] remain_dec;

    assign div_sel      = {div_reg[3], div_reg[1:0]};
    assign divisor      = (div_sel == lat_pkg::SEL_DIV_ONE) ? 8'd1 : (8'd2 << div_sel);
    assign prescale_inc = {1'b0, prescale_reg} + 8'd1;
    assign remain_dec   = remain_reg - {{(lat_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};

    always_comb
    begin
        spurious_next = spurious_reg;
        tpr_next      = tpr_reg;
        vector_next   = vector_reg;
        masked_next   = masked_reg;
        mode_next     = mode_reg;
        div_next      = div_reg;
        reload_next   = reload_reg;
        remain_next   = remain_reg;
        prescale_next = prescale_reg;
        result        = '0;

        case (item.cmd)
            lat_pkg::CMD_READ:
            begin
                case (item.reg_index)
                    lat_pkg::IDX_ID:   result.read_data = {unit_id, 24'd0};
                    lat_pkg::IDX_TPR:  result.read_data = {24'd0, tpr_reg};
                    lat_pkg::IDX_SPUR: result.read_data = {23'd0, spurious_reg};
                    lat_pkg::IDX_LVT:
                        result.read_data = {13'd0, mode_reg, masked_reg, 8'd0, vector_reg};
                    lat_pkg::IDX_INIT: result.read_data = 32'(reload_reg);
                    lat_pkg::IDX_CURR: result.read_data = 32'(remain_reg);
                    lat_pkg::IDX_DIV:  result.read_data = {28'd0, div_reg};
                    default:           result.read_data = '0;
                endcase
            end
            lat_pkg::CMD_WRITE:
            begin
                case (item.reg_index)
                    lat_pkg::IDX_TPR:  tpr_next = item.write_data[7:0];
                    lat_pkg::IDX_SPUR: spurious_next = item.write_data[8:0];
                    lat_pkg::IDX_LVT:
                    begin
                        vector_next = item.write_data[7:0];
                        masked_next = item.write_data[16];
                        mode_next   = item.write_data[18:17];
                    end
                    lat_pkg::IDX_INIT:
                    begin
                        reload_next   = item.write_data[lat_pkg::COUNT_WIDTH-1:0];
                        remain_next   = item.write_data[lat_pkg::COUNT_WIDTH-1:0];
                        prescale_next = '0;
                    end
                    lat_pkg::IDX_DIV:  div_next = {item.write_data[3], 1'b0,
                                                   item.write_data[1:0]};
                    default:           ;
                endcase
            end
            lat_pkg::CMD_TICK:
            begin
                if (remain_reg != '0)
                begin
                    if (prescale_inc >= divisor)
                    begin
                        prescale_next = '0;
                        remain_next   = remain_dec;
                        if (remain_dec == '0)
                        begin
                            if (spurious_reg[8] && !masked_reg)
                            begin
                                result.irq_fire   = 1'b1;
                                result.irq_vector = vector_reg;
                            end
                            if (mode_reg == lat_pkg::MODE_PERIODIC)
                            begin
                                remain_next = reload_reg;
                            end
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_inc[6:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spurious_reg <= 9'h0FF;
            tpr_reg      <= '0;
            vector_reg   <= '0;
            masked_reg   <= 1'b1;
            mode_reg     <= '0;
            div_reg      <= '0;
            reload_reg   <= '0;
            remain_reg   <= '0;
            prescale_reg <= '0;
        end
        else if (step_en)
        begin
            spurious_reg <= spurious_next;
            tpr_reg      <= tpr_next;
            vector_reg   <= vector_next;
            masked_reg   <= masked_next;
            mode_reg     <= mode_next;
            div_reg      <= div_next;
            reload_reg   <= reload_next;
            remain_reg   <= remain_next;
            prescale_reg <= prescale_next;
        end
    end

endmodule

`default_nettype wire

>>> test/testbench.sv
// Testbench for the local interrupt controller timer: drives bus words with random idling,
// predicts every result in a local timer model and compares it field by field.
// Depends on lat_pkg and the local_apic_timer_registers block.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_UNIT_ID = 3'd0;
    localparam int IDLE_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = lat_pkg::CMD_TICK;
    logic [5:0]  reg_index = '0;
    logic [31:0] write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic        irq_fire;
    logic [7:0]  irq_vector;

    lat_pkg::item_t   bus_words[$];
    lat_pkg::result_t due_outputs[$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      mismatches = 0;
    int      quiet_cycles = 0;

    logic [7:0]  m_unit_id = '0;
    logic [8:0]  m_spurious = 9'h0FF;
    logic [7:0]  m_tpr = '0;
    logic [7:0]  m_vector = '0;
    logic        m_masked = 1'b1;
    logic [1:0]  m_mode = '0;
    logic [3:0]  m_divide = '0;
    logic [31:0] m_reload = '0;
    logic [31:0] m_remaining = '0;
    logic [6:0]  m_prescale = '0;

    local_apic_timer_registers u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .reg_index  (reg_index),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .irq_fire   (irq_fire),
        .irq_vector (irq_vector)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic lat_pkg::result_t step_timer(lat_pkg::item_t w);
        lat_pkg::result_t r;
        logic [2:0]       sel;
        int unsigned      ratio;
        r = '0;
        if (w.cmd == lat_pkg::CMD_READ)
        begin
            case (w.reg_index)
                lat_pkg::IDX_ID:   r.read_data = {m_unit_id, 24'h0};
                lat_pkg::IDX_TPR:  r.read_data = {24'h0, m_tpr};
                lat_pkg::IDX_SPUR: r.read_data = {23'h0, m_spurious};
                lat_pkg::IDX_LVT:  r.read_data = {13'h0, m_mode, m_masked, 8'h0, m_vector};
                lat_pkg::IDX_INIT: r.read_data = m_reload;
                lat_pkg::IDX_CURR: r.read_data = m_remaining;
                lat_pkg::IDX_DIV:  r.read_data = {28'h0, m_divide};
                default:           r.read_data = '0;
            endcase
        end
        else if (w.cmd == lat_pkg::CMD_WRITE)
        begin
            case (w.reg_index)
                lat_pkg::IDX_TPR:  m_tpr = w.write_data[7:0];
                lat_pkg::IDX_SPUR: m_spurious = w.write_data[8:0];
                lat_pkg::IDX_LVT:
                begin
                    m_vector = w.write_data[7:0];
                    m_masked = w.write_data[16];
                    m_mode = w.write_data[18:17];
                end
                lat_pkg::IDX_INIT:
                begin
                    m_reload = w.write_data;
                    m_remaining = w.write_data;
                    m_prescale = '0;
                end
                lat_pkg::IDX_DIV:  m_divide = w.write_data[3:0] & 4'hB;
                default:  ;
            endcase
        end
        else if (w.cmd == lat_pkg::CMD_TICK && m_remaining != 0)
        begin
            sel = {m_divide[3], m_divide[1:0]};
            ratio = (sel == lat_pkg::SEL_DIV_ONE) ? 1 : (1 << (int'(sel) + 1));
            if (int'(m_prescale) + 1 >= ratio)
            begin
                m_prescale = '0;
                m_remaining = m_remaining - 32'd1;
                if (m_remaining == 0)
                begin
                    if (m_spurious[8] && !m_masked)
                    begin
                        r.irq_fire = 1'b1;
                        r.irq_vector = m_vector;
                    end
                    if (m_mode == lat_pkg::MODE_PERIODIC)
                        m_remaining = m_reload;
                end
            end
            else
            begin
                m_prescale = m_prescale + 7'd1;
            end
        end
        return r;
    endfunction

    // Mostly ticks and well-formed register traffic, with short counts and small
    // divisors so that the count expires often; a few words are pure noise.
    function automatic lat_pkg::item_t random_word();
        lat_pkg::item_t w;
        int unsigned    pick;
        w.cmd = lat_pkg::CMD_TICK;
        w.reg_index = 6'($urandom);
        w.write_data = $urandom;
        pick = $urandom_range(99);
        if (pick >= 55 && pick < 95)
        begin
            w.cmd = (pick < 70) ? lat_pkg::CMD_READ : lat_pkg::CMD_WRITE;
            case ($urandom_range(6))
                0: w.reg_index = lat_pkg::IDX_ID;
                1: w.reg_index = lat_pkg::IDX_TPR;
                2: w.reg_index = lat_pkg::IDX_SPUR;
                3: w.reg_index = lat_pkg::IDX_LVT;
                4: w.reg_index = lat_pkg::IDX_INIT;
                5: w.reg_index = lat_pkg::IDX_CURR;
                default: w.reg_index = lat_pkg::IDX_DIV;
            endcase
            case (w.reg_index)
                lat_pkg::IDX_INIT:
                begin
                    pick = $urandom_range(9);
                    if (pick < 7)
                        w.write_data = $urandom_range(1, 12);
                    else if (pick == 7)
                        w.write_data = '0;
                end
                lat_pkg::IDX_DIV:
                begin
                    if ($urandom_range(3) != 0)
                    begin
                        case ($urandom_range(3))
                            0: w.write_data[3:0] = 4'hB;
                            1: w.write_data[3:0] = 4'h0;
                            2: w.write_data[3:0] = 4'h1;
                            default: w.write_data[3:0] = 4'h2;
                        endcase
                    end
                end
                lat_pkg::IDX_LVT:
                begin
                    if ($urandom_range(3) != 0)
                        w.write_data[16] = 1'b0;
                end
                lat_pkg::IDX_SPUR:
                begin
                    if ($urandom_range(3) != 0)
                        w.write_data[8] = 1'b1;
                end
                default: ;
            endcase
        end
        else if (pick >= 95)
        begin
            w.cmd = 2'($urandom_range(3));
        end
        return w;
    endfunction

    task automatic queue_word(input logic [1:0] c, input logic [5:0] idx,
                              input logic [31:0] data);
        lat_pkg::item_t w;
        w.cmd = c;
        w.reg_index = idx;
        w.write_data = data;
        bus_words.push_back(w);
    endtask

    task automatic queue_random(input int count);
        @(negedge clk);
        repeat (count) bus_words.push_back(random_word());
    endtask

    task automatic drain();
        @(negedge clk);
        while (bus_words.size() != 0 || in_valid || due_outputs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_unit_id(input logic [7:0] id);
        logic [31:0] data;
        data = $urandom;
        data[7:0] = id;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_UNIT_ID;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        m_unit_id = id;
        @(negedge clk);
        if (prdata !== {24'h0, id})
        begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unit id read back %h, expected %h",
                         $realtime, prdata, {24'h0, id});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : feed_words
        lat_pkg::item_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_outputs.push_back(step_timer(lat_pkg::item_t'{cmd, reg_index, write_data}));
            if (!in_valid || !in_stall)
            begin
                if (bus_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = bus_words.pop_front();
                    cmd <= w.cmd;
                    reg_index <= w.reg_index;
                    write_data <= w.write_data;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        lat_pkg::result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_outputs.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected word read_data %h irq_fire %b irq_vector %h",
                                 $realtime, read_data, irq_fire, irq_vector);
                end
                else
                begin
                    want = due_outputs.pop_front();
                    if (read_data !== want.read_data || irq_fire !== want.irq_fire
                        || irq_vector !== want.irq_vector)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: expected %h %b %h, actual %h %b %h",
                                     $realtime, want.read_data, want.irq_fire,
                                     want.irq_vector, read_data, irq_fire, irq_vector);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : run_test
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 34;
        recv_idle_pct = 49;
        write_unit_id(8'hFF);
        @(negedge clk);
        queue_word(lat_pkg::CMD_READ, lat_pkg::IDX_ID, 32'h0);
        queue_word(lat_pkg::CMD_READ, lat_pkg::IDX_LVT, 32'h0);
        queue_word(lat_pkg::CMD_READ, 6'h3F, 32'hFFFF_FFFF);
        queue_word(CMD_UNUSED, 6'h3F, 32'hFFFF_FFFF);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_SPUR, 32'hFFFF_FFFF);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_LVT, 32'h0002_00FF);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_DIV, 32'hFFFF_FFFF);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_INIT, 32'h2);
        repeat (4) queue_word(lat_pkg::CMD_TICK, 6'h0, 32'h0);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_CURR, 32'hFFFF_FFFF);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_ID, 32'hFFFF_FFFF);
        queue_word(lat_pkg::CMD_READ, lat_pkg::IDX_CURR, 32'h0);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_TPR, 32'hFFFF_FFFF);
        queue_word(lat_pkg::CMD_READ, lat_pkg::IDX_TPR, 32'h0);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_DIV, 32'h0);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_INIT, 32'h0);
        queue_word(lat_pkg::CMD_TICK, 6'h0, 32'h0);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_INIT, 32'hFFFF_FFFF);
        repeat (2) queue_word(lat_pkg::CMD_TICK, 6'h0, 32'h0);
        queue_word(lat_pkg::CMD_WRITE, lat_pkg::IDX_LVT, 32'hFFFF_FFFF);
        queue_word(lat_pkg::CMD_READ, lat_pkg::IDX_LVT, 32'h0);
        queue_word(lat_pkg::CMD_WRITE, 6'h00, 32'hFFFF_FFFF);
        queue_random(150);
        drain();
        queue_random(150);
        drain();
        send_idle_pct = 49;
        recv_idle_pct = 34;
        write_unit_id(8'h00);
        queue_random(325);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_unit_id(8'($urandom_range(1, 254)));
        queue_random(325);
        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
